// ----- hw/rtl/qrcm_pkg.sv -----
`timescale 1ns / 1ps
package qrcm_pkg;

  localparam int unsigned ADDR_W = 3;

  localparam logic REG_CARRIER_STEP = 1'b0;
  localparam logic REG_AMPLITUDE    = 1'b1;

  localparam logic [31:0] CARRIER_STEP_RST = 32'd536870912;
  localparam logic [15:0] AMPLITUDE_RST    = 16'd32768;

  localparam logic KIND_SYMBOL = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // quarter-wave sine polynomial, Q30
  localparam logic [31:0] COEF1 = 32'd1686629713;
  localparam logic [31:0] COEF3 = 32'd693598668;
  localparam logic [31:0] COEF5 = 32'd85569306;
  localparam logic [31:0] COEF7 = 32'd5026995;
  localparam logic [31:0] COEF9 = 32'd172272;

  typedef struct packed {
    logic [31:0] carrier_step;
    logic [15:0] amplitude;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] quad;
  } slot_t;

endpackage

// ----- hw/rtl/qrcm_in_if.sv -----
`timescale 1ns / 1ps
interface qrcm_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [1:0] phase_shift;
  logic       silent;

  modport source (output valid, kind, phase_shift, silent, input ready);
  modport sink (input valid, kind, phase_shift, silent, output ready);
endinterface

// ----- hw/rtl/qrcm_out_if.sv -----
`timescale 1ns / 1ps
interface qrcm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

// ----- hw/rtl/qpsk_raised_cosine_modulator_core.sv -----
`timescale 1ns / 1ps
// Symbol word (kind 0): taken in S_IDLE, no output word; ready stays high.
// Tick word (kind 1): work on one shared 34x32 multiplier (3 sine
// evaluations of 7 steps each, then 3 mixing steps); ready stays low until
// the sample word is registered at the end (S_AMP waits while the output is full).
// Reset (rst, synchronous): quadrant 0, both slots silent, interval 0,
// carrier phase 0, registers at their defaults, no word pending.
module qpsk_raised_cosine_modulator_core
  import qrcm_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_SYMBOL = 256,
  parameter int unsigned SINE_TABLE_BITS    = 10
) (
  input  logic              clk,
  input  logic              rst,
  qrcm_in_if.sink           items,
  qrcm_out_if.source        samples,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned POS_W   = $clog2(SAMPLES_PER_SYMBOL);
  localparam int unsigned REM_W   = $clog2(SAMPLES_PER_SYMBOL);
  localparam int unsigned U_SHIFT = 18 - SINE_TABLE_BITS;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(SAMPLES_PER_SYMBOL - 1);
  localparam logic [REM_W:0]   SPS_C    = (REM_W+1)'(SAMPLES_PER_SYMBOL);
  localparam logic [17:0]      STEP_Q   = 18'(131072 / SAMPLES_PER_SYMBOL);
  localparam logic [REM_W:0]   STEP_R   = (REM_W+1)'(131072 % SAMPLES_PER_SYMBOL);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_SQ, S_HORN, S_FIN, S_MI, S_MQ, S_AMP
  } state_t;

  typedef enum logic [1:0] {
    EV_WEIGHT, EV_SIN, EV_COS
  } ev_t;

  cfg_t cfg;

  state_t state;
  ev_t    ev;
  logic [1:0]  hs;
  logic [1:0]  quad;
  slot_t       early;
  slot_t       late;
  logic [POS_W-1:0] pos;
  logic [17:0]      acc_a;
  logic [REM_W-1:0] acc_r;
  logic [31:0]      phase;
  logic             out_valid;

  logic [SINE_TABLE_BITS-1:0] k;
  logic [17:0]         wa;
  logic [30:0]         x;
  logic [30:0]         x2;
  logic [31:0]         t;
  logic signed [16:0]  w;
  logic signed [16:0]  sn;
  logic signed [16:0]  cs;
  logic signed [16:0]  ival;
  logic signed [16:0]  qval;
  logic signed [33:0]  m;
  logic signed [15:0]  out_sample;

  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [65:0] prod;

  logic [1:0]  qsel;
  logic [16:0] u_base;
  logic [16:0] u;
  logic        neg;
  logic [31:0] coef;
  logic [32:0] s_sum;
  logic [17:0] s_rnd;
  logic [16:0] s_mag;
  logic signed [17:0] s_val;
  logic signed [17:0] w_sum;
  logic signed [17:0] w18;
  logic signed [17:0] wl18;
  logic signed [17:0] i_sum;
  logic signed [17:0] q_sum;
  logic signed [65:0] y_full;
  logic signed [15:0] y_sat;
  logic [REM_W:0]     r_sum;

  qrcm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  function automatic logic signed [17:0] axis_term(slot_t s, logic q_axis,
                                                   logic signed [17:0] v);
    logic signed [17:0] r;
    r = '0;
    if (s.valid && (s.quad[0] == q_axis)) begin
      r = s.quad[1] ? -v : v;
    end
    return r;
  endfunction

  assign items.ready    = (state == S_IDLE);
  assign samples.valid  = out_valid;
  assign samples.sample = out_sample;

  // quarter-wave argument for the evaluation in progress
  always_comb begin
    qsel   = (ev == EV_COS) ? k[SINE_TABLE_BITS-1 -: 2] + 2'd1 : k[SINE_TABLE_BITS-1 -: 2];
    u_base = 17'({k[SINE_TABLE_BITS-3:0], {U_SHIFT{1'b0}}});
    if (ev == EV_WEIGHT) begin
      neg = (wa > 18'd65536);
      u   = neg ? 17'(wa - 18'd65536) : 17'(18'd65536 - wa);
    end else begin
      neg = qsel[1];
      u   = qsel[0] ? 17'd65536 - u_base : u_base;
    end
  end

  always_comb begin
    case (hs)
      2'd0:    coef = COEF7;
      2'd1:    coef = COEF5;
      2'd2:    coef = COEF3;
      default: coef = COEF1;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQ: begin
        mul_a = signed'({3'b0, x});
        mul_b = signed'({1'b0, x});
      end
      S_HORN: begin
        mul_a = signed'({3'b0, x2});
        mul_b = signed'(t);
      end
      S_FIN: begin
        mul_a = signed'({3'b0, x});
        mul_b = signed'(t);
      end
      S_MI: begin
        mul_a = 34'(ival);
        mul_b = 32'(cs);
      end
      S_MQ: begin
        mul_a = 34'(qval);
        mul_b = 32'(sn);
      end
      S_AMP: begin
        mul_a = m;
        mul_b = signed'({16'd0, cfg.amplitude});
      end
      default: ;
    endcase
  end

  assign prod = 66'(mul_a) * 66'(mul_b);

  always_comb begin
    s_sum = {1'b0, prod[61:30]} + 33'd16384;
    s_rnd = s_sum[32:15];
    s_mag = (s_rnd > 18'd32768) ? 17'd32768 : s_rnd[16:0];
    s_val = neg ? -signed'({1'b0, s_mag}) : signed'({1'b0, s_mag});
    w_sum = 18'sd32769 + s_val;
    w18   = 18'(w);
    wl18  = 18'sd32768 - w18;
    i_sum = axis_term(early, 1'b0, w18) + axis_term(late, 1'b0, wl18);
    q_sum = axis_term(early, 1'b1, w18) + axis_term(late, 1'b1, wl18);
    y_full = (prod + 66'sd536870912) >>> 30;
    if (y_full > 66'sd32767) begin
      y_sat = 16'sh7fff;
    end else if (y_full < -66'sd32768) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = y_full[15:0];
    end
    r_sum = {1'b0, acc_r} + STEP_R;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ev        <= EV_WEIGHT;
      hs        <= '0;
      quad      <= '0;
      early     <= '0;
      late      <= '0;
      pos       <= '0;
      acc_a     <= '0;
      acc_r     <= '0;
      phase     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (samples.valid && samples.ready && (state != S_AMP)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (items.valid) begin
            if (items.kind == KIND_SYMBOL) begin
              early <= late;
              if (items.silent) begin
                late <= '0;
              end else begin
                quad <= quad + items.phase_shift;
                late <= '{valid: 1'b1, quad: quad + items.phase_shift};
              end
              pos   <= '0;
              acc_a <= '0;
              acc_r <= '0;
            end else begin
              k     <= phase[31 -: SINE_TABLE_BITS];
              wa    <= acc_a;
              phase <= phase + cfg.carrier_step;
              if (pos != POS_LAST) begin
                pos <= pos + 1'b1;
                if (r_sum >= SPS_C) begin
                  acc_r <= REM_W'(r_sum - SPS_C);
                  acc_a <= acc_a + STEP_Q + 18'd1;
                end else begin
                  acc_r <= r_sum[REM_W-1:0];
                  acc_a <= acc_a + STEP_Q;
                end
              end
              ev    <= EV_WEIGHT;
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          x <= {u, 14'd0};
          if (ev == EV_SIN) begin
            ival <= i_sum[16:0];
            qval <= q_sum[16:0];
          end
          state <= S_SQ;
        end
        S_SQ: begin
          x2    <= prod[60:30];
          t     <= COEF9;
          hs    <= '0;
          state <= S_HORN;
        end
        S_HORN: begin
          t <= coef - prod[61:30];
          if (hs == 2'd3) begin
            state <= S_FIN;
          end else begin
            hs <= hs + 2'd1;
          end
        end
        S_FIN: begin
          case (ev)
            EV_WEIGHT: begin
              w     <= w_sum[17:1];
              ev    <= EV_SIN;
              state <= S_LOAD;
            end
            EV_SIN: begin
              sn    <= s_val[16:0];
              ev    <= EV_COS;
              state <= S_LOAD;
            end
            default: begin
              cs    <= s_val[16:0];
              state <= S_MI;
            end
          endcase
        end
        S_MI: begin
          m     <= prod[33:0];
          state <= S_MQ;
        end
        S_MQ: begin
          m     <= m - prod[33:0];
          state <= S_AMP;
        end
        S_AMP: begin
          if (!out_valid || samples.ready) begin
            out_valid  <= 1'b1;
            out_sample <= y_sat;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_LAST)
    else $error("interval position past the last sample");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, acc_r} < SPS_C)
    else $error("weight remainder out of range");

  a_origin: assert property (@(posedge clk) disable iff (rst)
    (pos == '0) |-> (acc_a == '0 && acc_r == '0))
    else $error("weight accumulator not at origin at interval start");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready && items.kind == KIND_TICK) |=> !items.ready)
    else $error("ready during tick processing");

  a_weight: assert property (@(posedge clk) disable iff (rst)
    (state == S_MI) |-> (w >= 17'sd0 && w <= 17'sd32768))
    else $error("weight out of range");

endmodule

// ----- hw/rtl/qrcm_cfg.sv -----
`timescale 1ns / 1ps
module qrcm_cfg
  import qrcm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic wr_en;
  logic reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[ADDR_W-1];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.carrier_step <= CARRIER_STEP_RST;
      cfg.amplitude    <= AMPLITUDE_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_CARRIER_STEP: cfg.carrier_step <= pwdata;
        REG_AMPLITUDE:    cfg.amplitude    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CARRIER_STEP: prdata = cfg.carrier_step;
      REG_AMPLITUDE:    prdata = {16'd0, cfg.amplitude};
      default:          prdata = '0;
    endcase
  end

endmodule
